>>> sv/binarized_3x3_texture_energy_defines.svh
// Assertion macros shared by the texture energy block.
`ifndef BINARIZED_3X3_TEXTURE_ENERGY_DEFINES_SVH
`define BINARIZED_3X3_TEXTURE_ENERGY_DEFINES_SVH

// Immediate implication checked at every clock edge outside reset.
`define BTE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define BTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bte_pkg.sv
package bte_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int DIM_W = 12;
	localparam int THR_W = 9;
	localparam int KER_W = 36;
	localparam int CFG_W = 36;
	localparam int SUM_W = 32;

	localparam int LUMA_SUM_W = 24;
	localparam int RESP_W     = 8;
	localparam int Q_DEPTH    = 4;

	localparam logic [15:0] WEIGHT_RED   = 16'd19595;
	localparam logic [15:0] WEIGHT_GREEN = 16'd38470;
	localparam logic [15:0] WEIGHT_BLUE  = 16'd7471;

	localparam logic [1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_KERNEL    = 2'd1;
	localparam logic [1:0] CFG_WIDTH     = 2'd2;
	localparam logic [1:0] CFG_HEIGHT    = 2'd3;

	typedef struct packed {
		logic [THR_W-1:0] threshold;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
	} front_cfg_t;

	typedef struct packed {
		logic             pix_bit;
		logic [COL_W-1:0] x;
		logic             interior;
		logic             eof;
	} pix_item_t;

endpackage

>>> sv/binarized_3x3_texture_energy.sv
// The frame sum travels through the front register, the queue and the back-end stages.
// Throughput: one pixel per cycle unless in_stall is raised; the line memory is read
// and written once per pixel on its single port pair, and one result leaves per frame.
// Reset: counters, window, accumulator, queue and valids clear at once; configuration
// returns to its reset values; the line memory is not cleared and needs no clearing pass.
`include "binarized_3x3_texture_energy_defines.svh"

module binarized_3x3_texture_energy (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [1:0]                  cfg_index,
	input  logic [bte_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bte_pkg::SUM_W-1:0]   texture_sum,
	output logic                        sum_saturated
);
	import bte_pkg::*;

	front_cfg_t       front_cfg_q;
	logic [KER_W-1:0] kernel_q;

	logic      q_push;
	pix_item_t q_push_item;
	logic      q_full;
	logic      q_valid;
	pix_item_t q_item;
	logic      q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_cfg_q.threshold    <= THR_W'(128);
			front_cfg_q.image_width  <= DIM_W'(2048);
			front_cfg_q.image_height <= DIM_W'(2048);
			kernel_q                 <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_THRESHOLD: front_cfg_q.threshold    <= cfg_data[THR_W-1:0];
				CFG_KERNEL:    kernel_q                 <= cfg_data[KER_W-1:0];
				CFG_WIDTH:     front_cfg_q.image_width  <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT:    front_cfg_q.image_height <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	bte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (front_cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.push      (q_push),
		.push_item (q_push_item),
		.q_full    (q_full)
	);

	bte_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop_item  (q_item),
		.pop       (q_pop)
	);

	bte_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.kernel_weights (kernel_q),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.texture_sum    (texture_sum),
		.sum_saturated  (sum_saturated)
	);

	`BTE_ASSERT_IMPL(a_no_push_when_full, q_push, !q_full, "transfer into a full queue")
	`BTE_ASSERT_IMPL(a_stall_only_when_full, in_stall, q_full, "input stalled with queue room")
	`BTE_ASSERT_IMPL(a_sat_means_max, out_valid && sum_saturated, texture_sum == '1, "flag, no max")
	`BTE_ASSERT_IMPL(a_pop_needs_data, q_pop, q_valid, "queue popped while empty")

endmodule

>>> sv/bte_front.sv
module bte_front (
	input  logic                clk,
	input  logic                arst_n,
	input  bte_pkg::front_cfg_t cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	output logic                push,
	output bte_pkg::pix_item_t  push_item,
	input  logic                q_full
);
	import bte_pkg::*;

	logic accept;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W:0]   col_inc;
	logic [ROW_W:0]   row_inc;
	logic [COL_W:0]   w_eff;
	logic [ROW_W:0]   h_eff;
	logic             row_end;
	logic             frame_end;

	logic                  valid_s1;
	logic [LUMA_SUM_W-1:0] prod_r_s1;
	logic [LUMA_SUM_W-1:0] prod_g_s1;
	logic [LUMA_SUM_W-1:0] prod_b_s1;
	logic [COL_W-1:0]      x_s1;
	logic                  interior_s1;
	logic                  eof_s1;
	logic [LUMA_SUM_W-1:0] luma_sum;
	logic [7:0]            luma;

	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !q_full;

	always_comb begin
		if (cfg.image_width < DIM_W'(3))
			w_eff = (COL_W+1)'(3);
		else if (32'(cfg.image_width) > MAX_WIDTH)
			w_eff = (COL_W+1)'(MAX_WIDTH);
		else
			w_eff = (COL_W+1)'(cfg.image_width);
		if (cfg.image_height < DIM_W'(3))
			h_eff = (ROW_W+1)'(3);
		else if (32'(cfg.image_height) > MAX_HEIGHT)
			h_eff = (ROW_W+1)'(MAX_HEIGHT);
		else
			h_eff = (ROW_W+1)'(cfg.image_height);
	end

	assign col_inc   = {1'b0, col_q} + (COL_W+1)'(1);
	assign row_inc   = {1'b0, row_q} + (ROW_W+1)'(1);
	assign row_end   = col_inc >= w_eff;
	assign frame_end = row_end && (row_inc >= h_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (!row_end) begin
				col_q <= col_inc[COL_W-1:0];
			end else begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_inc[ROW_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (push)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_r_s1   <= LUMA_SUM_W'(red) * LUMA_SUM_W'(WEIGHT_RED);
			prod_g_s1   <= LUMA_SUM_W'(green) * LUMA_SUM_W'(WEIGHT_GREEN);
			prod_b_s1   <= LUMA_SUM_W'(blue) * LUMA_SUM_W'(WEIGHT_BLUE);
			x_s1        <= col_q;
			interior_s1 <= (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));
			eof_s1      <= frame_end;
		end
	end

	// The weights sum to 65536, so the total never leaves 24 bits.
	assign luma_sum = prod_r_s1 + prod_g_s1 + prod_b_s1;
	assign luma     = luma_sum[LUMA_SUM_W-1 -: 8];

	always_comb begin
		push_item.pix_bit  = {1'b0, luma} > cfg.threshold;
		push_item.x        = x_s1;
		push_item.interior = interior_s1;
		push_item.eof      = eof_s1;
	end

endmodule

>>> sv/bte_queue.sv
module bte_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bte_pkg::pix_item_t push_item,
	output logic               full,
	output logic               pop_valid,
	output bte_pkg::pix_item_t pop_item,
	input  logic               pop
);
	import bte_pkg::*;

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	pix_item_t        slot_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(Q_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_item;
	end

endmodule

>>> sv/bte_back.sv
module bte_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bte_pkg::KER_W-1:0]   kernel_weights,
	input  logic                        q_valid,
	input  bte_pkg::pix_item_t          q_item,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bte_pkg::SUM_W-1:0]   texture_sum,
	output logic                        sum_saturated
);
	import bte_pkg::*;

	// Each entry holds the bits of the two previous rows at one column.
	logic [1:0] line_mem [MAX_WIDTH];

	logic             valid_s1;
	pix_item_t        item_s1;
	logic [1:0]       rd_s1;
	logic             adv_s1;

	logic [2:0][2:0]  win_q;
	logic [2:0][2:0]  win_next;
	logic signed [RESP_W-1:0] resp;

	logic                     valid_s2;
	logic signed [RESP_W-1:0] resp_s2;
	logic                     interior_s2;
	logic                     eof_s2;
	logic                     fire_s2;

	logic [SUM_W-1:0] acc_q;
	logic             sat_q;
	logic [RESP_W-1:0] mag;
	logic [SUM_W:0]    sum_wide;
	logic [SUM_W-1:0]  acc_next;
	logic              sat_next;
	logic              out_free;

	assign out_free = !out_valid || !out_stall;
	assign fire_s2  = valid_s2 && (!eof_s2 || out_free);
	assign adv_s1   = valid_s1 && (!valid_s2 || fire_s2);
	assign q_pop    = q_valid && (!valid_s1 || adv_s1);

	// The write of one column and the read of the next column may share an edge;
	// the same column comes back only after at least three transfers.
	always_ff @(posedge clk) begin
		if (q_pop)
			rd_s1 <= line_mem[q_item.x];
		if (adv_s1)
			line_mem[item_s1.x] <= {rd_s1[0], item_s1.pix_bit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (q_pop)
			valid_s1 <= 1'b1;
		else if (adv_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			item_s1 <= q_item;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_next[i][0] = win_q[i][1];
			win_next[i][1] = win_q[i][2];
		end
		win_next[0][2] = rd_s1[1];
		win_next[1][2] = rd_s1[0];
		win_next[2][2] = item_s1.pix_bit;
	end

	always_comb begin
		resp = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (win_next[i][j])
					resp = resp + RESP_W'(signed'(kernel_weights[4*(3*i+j) +: 4]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_q <= '0;
		else if (adv_s1)
			win_q <= item_s1.eof ? '0 : win_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv_s1)
			valid_s2 <= 1'b1;
		else if (fire_s2)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			resp_s2     <= resp;
			interior_s2 <= item_s1.interior;
			eof_s2      <= item_s1.eof;
		end
	end

	assign mag      = resp_s2[RESP_W-1] ? RESP_W'(-resp_s2) : RESP_W'(resp_s2);
	assign sum_wide = {1'b0, acc_q} + (SUM_W+1)'(mag);

	// A sum that reaches the maximum sticks there and raises the flag.
	always_comb begin
		acc_next = acc_q;
		sat_next = sat_q;
		if (interior_s2) begin
			if (sum_wide[SUM_W] || (sum_wide[SUM_W-1:0] == '1)) begin
				acc_next = '1;
				sat_next = 1'b1;
			end else begin
				acc_next = sum_wide[SUM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			sat_q <= 1'b0;
		end else if (fire_s2) begin
			acc_q <= eof_s2 ? '0 : acc_next;
			sat_q <= eof_s2 ? 1'b0 : sat_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (fire_s2 && eof_s2)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire_s2 && eof_s2) begin
			texture_sum   <= acc_next;
			sum_saturated <= sat_next;
		end
	end

endmodule
